/* hdl/assert_macros.svh */
// Assertion macros shared by the parser RTL.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CHECK_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequence must hold at the next clock edge after the trigger.
`define CHECK_NEXT(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

/* hdl/stip_pkg.sv */
// Shared types, constants and character helpers of the string-to-integer parser.
// No dependencies; used by stip_ctrl, stip_dp and the top level.
package stip_pkg;

   localparam int WORD_BITS     = 32;
   localparam int BASE_BITS     = 6;
   localparam int CH_BITS       = 8;
   localparam int CONSUMED_BITS = 12;
   localparam int MAX_LEN       = 4096;
   localparam int CNT_BITS      = $clog2(MAX_LEN);
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_LEN - 1);
   localparam int PROD_BITS     = WORD_BITS + BASE_BITS;
   localparam int SUM_BITS      = PROD_BITS + 1;

   // Stream and register port sizes
   localparam int REQ_TDATA_BITS = CH_BITS;
   localparam int RSP_TDATA_BITS = ((WORD_BITS + CONSUMED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - WORD_BITS - CONSUMED_BITS;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam logic REG_NUMBER_BASE = 1'b0;

   typedef logic [1:0] sign_type;
   localparam sign_type SG_NONE  = 2'd0;
   localparam sign_type SG_PLUS  = 2'd1;
   localparam sign_type SG_MINUS = 2'd2;

   localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
   localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
   localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);

   localparam logic [CH_BITS-1:0] CH_TAB      = 8'h09;
   localparam logic [CH_BITS-1:0] CH_CR       = 8'h0D;
   localparam logic [CH_BITS-1:0] CH_SPACE    = 8'h20;
   localparam logic [CH_BITS-1:0] CASE_BIT    = 8'h20;
   localparam logic [CH_BITS-1:0] CH_PLUS     = 8'h2B;
   localparam logic [CH_BITS-1:0] CH_MINUS    = 8'h2D;
   localparam logic [CH_BITS-1:0] CH_ZERO     = 8'h30;
   localparam logic [CH_BITS-1:0] CH_NINE     = 8'h39;
   localparam logic [CH_BITS-1:0] CH_LOWER_A  = 8'h61;
   localparam logic [CH_BITS-1:0] CH_LOWER_X  = 8'h78;
   localparam logic [CH_BITS-1:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [CH_BITS-1:0] DIGIT_ALPHA = 8'd10;

   // Controller to datapath
   typedef struct packed {
      logic                 restart;  // zero the accumulator for this beat
      logic                 mac;      // accumulator <= accumulator * base + digit
      logic                 emit;     // load the result register
      logic                 ovf;      // result saturates to the clamp
      sign_type             sign;
      logic [BASE_BITS-1:0] base;
      logic [CNT_BITS-1:0]  count;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic digit_ok;  // character is a digit below the base
      logic mac_ovf;   // taking it would pass the clamp
   } status_type;

   function automatic logic is_space(input logic [CH_BITS-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // MSB flags a digit or letter, low bits carry its value
   function automatic logic [BASE_BITS:0] digit_of(input logic [CH_BITS-1:0] c);
      logic [CH_BITS-1:0] l;
      logic [BASE_BITS:0] r;
      l = c | CASE_BIT;
      r = '0;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         r = {1'b1, BASE_BITS'(c - CH_ZERO)};
      end else if ((l >= CH_LOWER_A) && (l <= CH_LOWER_Z)) begin
         r = {1'b1, BASE_BITS'(l - CH_LOWER_A + DIGIT_ALPHA)};
      end
      return r;
   endfunction

   function automatic logic [WORD_BITS-1:0] clamp_of(input sign_type s);
      logic [WORD_BITS-1:0] r;
      r = '1;
      if (s == SG_MINUS) begin
         r = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else if (s == SG_PLUS) begin
         r = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* hdl/stip_ctrl.sv */
// Parser controller: phase state machine, sign, latched base and character count.
// Depends on stip_pkg and assert_macros.svh; drives stip_dp through cmd_type.
`include "assert_macros.svh"

module stip_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [stip_pkg::CH_BITS-1:0]   ch,
   input  logic                           start,
   input  logic [stip_pkg::BASE_BITS-1:0] number_base,
   input  stip_pkg::status_type           status,
   output stip_pkg::cmd_type              cmd
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_FIRST  = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   logic [2:0]                     phase_ff, phase_in, phase_cur, phase_a;
   stip_pkg::sign_type             sign_ff, sign_in, sign_cur, sign_a;
   logic [stip_pkg::BASE_BITS-1:0] base_ff, base_in, base_cur, base_a, base_take;
   logic [stip_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in, cnt_cur;
   logic start_now, take, first_char, adv_a, adv, mac, emit, ovf;

   assign start_now = step && start;

   // Decode the character against the current phase; no datapath status here
   always_comb begin
      phase_cur  = start_now ? PH_LEAD : phase_ff;
      sign_cur   = start_now ? stip_pkg::SG_NONE : sign_ff;
      base_cur   = start_now ? number_base : base_ff;
      cnt_cur    = start_now ? '0 : cnt_ff;
      take       = 1'b0;
      first_char = 1'b0;
      base_take  = base_cur;
      phase_a    = phase_cur;
      sign_a     = sign_cur;
      base_a     = base_cur;
      adv_a      = 1'b0;
      unique case (phase_cur)
         PH_LEAD: begin
            priority if (stip_pkg::is_space(ch)) begin
               adv_a = 1'b1;
            end else if ((ch == stip_pkg::CH_PLUS) || (ch == stip_pkg::CH_MINUS)) begin
               sign_a  = (ch == stip_pkg::CH_MINUS) ? stip_pkg::SG_MINUS : stip_pkg::SG_PLUS;
               phase_a = PH_FIRST;
               adv_a   = 1'b1;
            end else begin
               first_char = 1'b1;
            end
         end
         PH_FIRST: begin
            first_char = 1'b1;
         end
         PH_ZERO: begin
            if ((ch | stip_pkg::CASE_BIT) == stip_pkg::CH_LOWER_X) begin
               base_a  = stip_pkg::BASE_HEX;
               phase_a = PH_DIGITS;
               adv_a   = 1'b1;
            end else begin
               take = 1'b1;
               if (base_cur == stip_pkg::BASE_AUTO) base_take = stip_pkg::BASE_OCT;
            end
         end
         PH_DIGITS: begin
            take = 1'b1;
         end
         default: ;
      endcase
      if (first_char) begin
         if (((base_cur == stip_pkg::BASE_AUTO) || (base_cur == stip_pkg::BASE_HEX)) &&
             (ch == stip_pkg::CH_ZERO)) begin
            phase_a = PH_ZERO;
            adv_a   = 1'b1;
         end else begin
            take = 1'b1;
            if (base_cur == stip_pkg::BASE_AUTO) base_take = stip_pkg::BASE_DEC;
         end
      end
   end

   // Resolve digit beats with the datapath status
   always_comb begin
      phase_in = phase_ff;
      sign_in  = sign_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      ovf      = 1'b0;
      mac      = 1'b0;
      adv      = 1'b0;
      if (step) begin
         phase_in = phase_a;
         sign_in  = sign_a;
         base_in  = base_a;
         cnt_in   = cnt_cur;
         adv      = adv_a;
         if (take) begin
            phase_in = PH_DIGITS;
            base_in  = base_take;
            priority if (!status.digit_ok) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end else if (status.mac_ovf) begin
               emit     = 1'b1;
               ovf      = 1'b1;
               phase_in = PH_DONE;
            end else begin
               mac = 1'b1;
               adv = 1'b1;
            end
         end
         if (adv && (cnt_cur != stip_pkg::CNT_MAX)) begin
            cnt_in = cnt_cur + stip_pkg::CNT_BITS'(1);
         end
      end
   end

   assign cmd.restart = start_now;
   assign cmd.mac     = mac;
   assign cmd.emit    = emit;
   assign cmd.ovf     = ovf;
   assign cmd.sign    = sign_cur;
   assign cmd.base    = base_take;
   assign cmd.count   = cnt_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sign_ff  <= stip_pkg::SG_NONE;
         base_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         sign_ff  <= sign_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
      end
   end

   `CHECK_NEXT(a_emit_then_done, clock, reset, cmd.emit, phase_ff == PH_DONE, "emit did not close the number")
   `CHECK_HOLDS(a_digits_have_base, clock, reset, (phase_ff != PH_DIGITS) || (base_ff != '0), "digit phase with base zero")

endmodule

/* hdl/stip_dp.sv */
// Parser datapath: digit decode, multiply-add accumulator, clamp check, result register.
// Depends on stip_pkg and assert_macros.svh; commanded by stip_ctrl.
`include "assert_macros.svh"

module stip_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [stip_pkg::CH_BITS-1:0]       ch,
   input  stip_pkg::cmd_type                  cmd,
   output stip_pkg::status_type               status,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [stip_pkg::WORD_BITS-1:0]     rsp_value,
   output logic [stip_pkg::CONSUMED_BITS-1:0] rsp_consumed,
   output logic                               rsp_overflowed
);

   logic [stip_pkg::BASE_BITS:0]          digit;
   logic [stip_pkg::WORD_BITS-1:0]        acc_ff, acc_cur, clamp, emit_mag;
   logic [stip_pkg::PROD_BITS-1:0]        prod;
   logic [stip_pkg::SUM_BITS-1:0]         sum;
   logic                                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [stip_pkg::WORD_BITS-1:0]        rsp_value_ff;
   logic [stip_pkg::CONSUMED_BITS-1:0]    rsp_consumed_ff;
   logic                                  rsp_ovf_ff;

   assign digit   = stip_pkg::digit_of(ch);
   assign acc_cur = cmd.restart ? '0 : acc_ff;
   assign clamp   = stip_pkg::clamp_of(cmd.sign);

   // acc * base + digit > clamp is the exact overflow test
   assign prod = stip_pkg::PROD_BITS'(acc_cur) * stip_pkg::PROD_BITS'(cmd.base);
   assign sum  = stip_pkg::SUM_BITS'(prod) +
                 stip_pkg::SUM_BITS'(digit[stip_pkg::BASE_BITS-1:0]);

   assign status.digit_ok = digit[stip_pkg::BASE_BITS] &&
                            (digit[stip_pkg::BASE_BITS-1:0] < cmd.base);
   assign status.mac_ovf  = sum > stip_pkg::SUM_BITS'(clamp);

   assign emit_mag = cmd.ovf ? clamp : acc_cur;

   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         acc_ff <= sum[stip_pkg::WORD_BITS-1:0];
      end else if (cmd.restart) begin
         acc_ff <= '0;
      end
   end

   assign rsp_tvalid_in = cmd.emit || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff    <= (cmd.sign == stip_pkg::SG_MINUS) ?
                            (stip_pkg::WORD_BITS'(0) - emit_mag) : emit_mag;
         rsp_consumed_ff <= (emit_mag != '0) ? stip_pkg::CONSUMED_BITS'(cmd.count) : '0;
         rsp_ovf_ff      <= cmd.ovf;
      end
   end

   assign rsp_tvalid     = rsp_tvalid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_consumed   = rsp_consumed_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   `CHECK_HOLDS(a_no_overrun, clock, reset, !cmd.emit || !rsp_tvalid_ff || rsp_tready, "result overwritten before taken")
   `CHECK_HOLDS(a_zero_iff_empty, clock, reset, !rsp_tvalid_ff || ((rsp_value_ff == '0) == (rsp_consumed_ff == '0)), "consumed count disagrees with value")

endmodule

/* hdl/string_to_integer_parser_unit.sv */
// String-to-integer parser, strtol style: one character per input beat,
// one result beat per number. Depends on stip_pkg, stip_ctrl and stip_dp.
//  - req channel: one ASCII character per beat in req_tdata; req_tuser marks
//    the first character of a new string, which clears the parse and latches
//    the base register. Characters before any start, or after a number has
//    ended, are dropped until the next start.
//  - rsp channel: one beat per number, sent when the first character that is
//    not a digit of the base arrives, or when a digit would pass the clamp
//    (then value is the clamp and rsp_tuser is set).
//  - csr port: register number_base at byte address 0; 0 selects automatic
//    0 / 0x prefix detection. It takes effect at the next string start.
//  - Throughput: one character per cycle while req_tready is high. The
//    character decode, the 32x6 multiply-add and the clamp compare of the
//    accumulator loop are all combinational.
//  - Latency: the result beat is valid the cycle after the ending character.
//  - Stall: a single result register sits on the output; req_tready stays
//    high while it is empty or being taken, and drops while a result waits
//    on a stalled receiver.
//  - Reset: synchronous; clears the parse phase, the result valid and the
//    base register, after which the block waits for a start beat.

module string_to_integer_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   // input characters
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [stip_pkg::REQ_TDATA_BITS-1:0] req_tdata,  // [7:0] ch
   input  logic                                req_tuser,  // [0] start_req
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stip_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // [31:0] value, [43:32] consumed
   output logic                                rsp_tuser,  // [0] overflowed
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [stip_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [stip_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [stip_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [stip_pkg::BASE_BITS-1:0]     number_base_ff;
   logic                               reg_sel, reg_wr, step;
   stip_pkg::cmd_type                  cmd;
   stip_pkg::status_type               status;
   logic [stip_pkg::WORD_BITS-1:0]     value;
   logic [stip_pkg::CONSUMED_BITS-1:0] consumed;

   // Register access: word index sits above the byte offset
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[stip_pkg::CSR_ADDR_BITS-1] == stip_pkg::REG_NUMBER_BASE;
   assign reg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign csr_prdata = reg_sel ? stip_pkg::CSR_DATA_BITS'(number_base_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= '0;
      end else if (reg_wr) begin
         number_base_ff <= csr_pwdata[stip_pkg::BASE_BITS-1:0];
      end
   end

   // Accept a character whenever the result register can take its outcome
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign step       = req_tvalid && req_tready;

   stip_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .ch          (req_tdata[stip_pkg::CH_BITS-1:0]),
      .start       (req_tuser),
      .number_base (number_base_ff),
      .status      (status),
      .cmd         (cmd)
   );

   stip_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ch             (req_tdata[stip_pkg::CH_BITS-1:0]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_value      (value),
      .rsp_consumed   (consumed),
      .rsp_overflowed (rsp_tuser)
   );

   // Pack value low, consumed above it, zero pad to whole bytes
   assign rsp_tdata = {{stip_pkg::RSP_PAD_BITS{1'b0}}, consumed, value};

endmodule

/* bench/string_to_integer_parser_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for string_to_integer_parser_unit: streams hand-picked and random
// strings under a series of base settings and checks every result beat against a predictor.
// Depends on stip_pkg and the parser RTL only.

module string_to_integer_parser_unit_tb;

   localparam int PERIOD        = 20;
   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_LIMIT    = 3000;  // cycles without any beat before giving up
   localparam int LIVE_TARGET   = 1500;  // parsed characters, in total, before the random part may end
   localparam int PHASE_CHARS   = 150;   // parsed characters per base setting
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;     // result lands in the cycle after its character
   localparam int TAIL_CYCLES   = 8;
   localparam int REPORT_MAX    = 10;
   localparam logic [stip_pkg::CSR_ADDR_BITS-1:0] NUMBER_BASE_ADDR =
      stip_pkg::CSR_ADDR_BITS'({stip_pkg::REG_NUMBER_BASE, 2'b00});

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEAD, PH_FIRST, PH_ZERO, PH_DIGITS, PH_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [stip_pkg::WORD_BITS-1:0]     value;
      logic [stip_pkg::CONSUMED_BITS-1:0] consumed;
      logic                               overflowed;
   } number_type;

   typedef logic [7:0] char_q_type[$];

   // Predicts the number each string yields and checks result beats in order.
   class number_scoreboard;
      logic [stip_pkg::BASE_BITS-1:0] base_reg;
      parse_phase_type                phase;
      logic [63:0]                    acc;
      stip_pkg::sign_type             sign;
      logic [stip_pkg::BASE_BITS-1:0] base_now;
      logic [stip_pkg::CNT_BITS-1:0]  count;
      number_type                     expected_q[$];
      int live_chars, strings, results, overflows, checked, mismatches;

      function new();
         base_reg   = stip_pkg::BASE_AUTO;
         phase      = PH_IDLE;
         acc        = '0;
         sign       = stip_pkg::SG_NONE;
         base_now   = stip_pkg::BASE_AUTO;
         count      = '0;
         live_chars = 0;
         strings    = 0;
         results    = 0;
         overflows  = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      function void set_base(logic [stip_pkg::BASE_BITS-1:0] b);
         base_reg = b;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int digit_value(logic [7:0] c);
         logic [7:0] l;
         l = c | stip_pkg::CASE_BIT;
         if (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_NINE)
            return int'(c - stip_pkg::CH_ZERO);
         if (l >= stip_pkg::CH_LOWER_A && l <= stip_pkg::CH_LOWER_Z)
            return int'(l - stip_pkg::CH_LOWER_A) + int'(stip_pkg::DIGIT_ALPHA);
         return -1;
      endfunction

      function logic [63:0] clamp_now();
         logic [63:0] umax;
         umax = (64'd1 << stip_pkg::WORD_BITS) - 64'd1;
         if (sign == stip_pkg::SG_MINUS) return (umax >> 1) + 64'd1;
         if (sign == stip_pkg::SG_PLUS) return umax >> 1;
         return umax;
      endfunction

      function void finish_number(logic ovf);
         number_type  r;
         logic [63:0] v;
         v            = (sign == stip_pkg::SG_MINUS) ? (64'd0 - acc) : acc;
         r.value      = v[stip_pkg::WORD_BITS-1:0];
         r.consumed   = (acc != 64'd0) ? stip_pkg::CONSUMED_BITS'(count) : '0;
         r.overflowed = ovf;
         expected_q.push_back(r);
         phase = PH_DONE;
         results++;
         if (ovf) overflows++;
      endfunction

      // Returns 1 when the character ended the number.
      function bit take_digit(logic [7:0] c);
         int          d;
         logic [63:0] lim;
         phase = PH_DIGITS;
         d     = digit_value(c);
         if (d < 0 || d >= int'(base_now)) begin
            finish_number(1'b0);
            return 1'b1;
         end
         lim = clamp_now();
         if (acc > (lim - 64'(d)) / 64'(base_now)) begin
            acc = lim;
            finish_number(1'b1);
            return 1'b1;
         end
         acc = acc * 64'(base_now) + 64'(d);
         return 1'b0;
      endfunction

      function void note_char(logic [7:0] c, logic opens);
         bit ended;
         bit to_first;
         ended    = 1'b0;
         to_first = 1'b0;
         if (opens) begin
            phase    = PH_LEAD;
            acc      = '0;
            sign     = stip_pkg::SG_NONE;
            base_now = base_reg;
            count    = '0;
            strings++;
         end
         if (phase == PH_IDLE || phase == PH_DONE) return;
         live_chars++;
         case (phase)
            PH_LEAD: begin
               if (!(c == stip_pkg::CH_SPACE ||
                     (c >= stip_pkg::CH_TAB && c <= stip_pkg::CH_CR))) begin
                  if (c == stip_pkg::CH_MINUS || c == stip_pkg::CH_PLUS) begin
                     sign  = (c == stip_pkg::CH_MINUS) ? stip_pkg::SG_MINUS
                                                       : stip_pkg::SG_PLUS;
                     phase = PH_FIRST;
                  end else begin
                     to_first = 1'b1;
                  end
               end
            end
            PH_FIRST: to_first = 1'b1;
            PH_ZERO: begin
               if ((c | stip_pkg::CASE_BIT) == stip_pkg::CH_LOWER_X) begin
                  base_now = stip_pkg::BASE_HEX;
                  phase    = PH_DIGITS;
               end else begin
                  if (base_now == stip_pkg::BASE_AUTO) base_now = stip_pkg::BASE_OCT;
                  ended = take_digit(c);
               end
            end
            default: ended = take_digit(c);
         endcase
         if (to_first) begin
            if ((base_now == stip_pkg::BASE_AUTO || base_now == stip_pkg::BASE_HEX) &&
                c == stip_pkg::CH_ZERO) begin
               phase = PH_ZERO;
            end else begin
               if (base_now == stip_pkg::BASE_AUTO) base_now = stip_pkg::BASE_DEC;
               ended = take_digit(c);
            end
         end
         if (!ended && count != stip_pkg::CNT_MAX) count++;
      endfunction

      function void check_result(number_type got);
         number_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] result beat with none pending: value %h consumed %0d ovf %0b",
                        $time, got.value, got.consumed, got.overflowed);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.value !== want.value || got.consumed !== want.consumed ||
             got.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] result %0d: value %h/%h consumed %0d/%0d ovf %0b/%0b (exp/got)",
                        $time, checked, want.value, got.value, want.consumed, got.consumed,
                        want.overflowed, got.overflowed);
         end
      endfunction
   endclass

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [stip_pkg::REQ_TDATA_BITS-1:0] req_tdata   = '0;    // [7:0] ch
   logic                                req_tuser   = 1'b0;  // [0] start_req
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [stip_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;  // [31:0] value, [43:32] consumed
   logic                                rsp_tuser;  // [0] overflowed
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [stip_pkg::CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [stip_pkg::CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [stip_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   number_scoreboard sb = new();
   int  idle_cycles   = 0;
   int  burst_left    = 0;
   int  base_settings = 0;
   bit  hold_off_req  = 1'b0;

   string_to_integer_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Observe every handshake at the edge where it completes; the predictor sees
   // characters, base writes and result beats in exactly the order the block does.
   always @(posedge clock) begin
      number_type got;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == NUMBER_BASE_ADDR)
            sb.set_base(csr_pwdata[stip_pkg::BASE_BITS-1:0]);
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            got.value      = rsp_tdata[stip_pkg::WORD_BITS-1:0];
            got.consumed   = rsp_tdata[stip_pkg::WORD_BITS +: stip_pkg::CONSUMED_BITS];
            got.overflowed = rsp_tuser;
            sb.check_result(got);
         end
      end
   end

   // Watchdog: any beat on either stream restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no beat for %0d cycles, %0d results still pending",
                  $time, IDLE_LIMIT, sb.pending());
         $display("string_to_integer_parser_unit: mismatch");
         $finish;
      end
   end

   // Receiver: switch at random between stall patterns, and honor one long hold-off
   // when the stimulus asks for it so the result register backs up into the input.
   initial begin : rsp_side
      int mode;
      int mode_left;
      int hold_left;
      bit held;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      held      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 0);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
         @(posedge clock);
      end
   end

   // Offer one character and hold it until taken. Between bursts drop valid for a
   // random gap; some bursts are long enough to run with no gaps at all.
   task automatic push_char(input logic [7:0] c, input logic opens);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= opens;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_string(input char_q_type s);
      foreach (s[i]) push_char(s[i], i == 0);
   endtask

   // Drop valid and wait until every predicted result has come back, then allow
   // for characters that were still being parsed without producing a result.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Two-phase register write; random upper bits exercise the field mask.
   task automatic write_base(input logic [stip_pkg::BASE_BITS-1:0] b);
      logic [stip_pkg::CSR_DATA_BITS-1:0] word;
      word                          = $urandom;
      word[stip_pkg::BASE_BITS-1:0] = b;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= NUMBER_BASE_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      base_settings++;
   endtask

   function automatic logic [7:0] digit_char(int d, bit upper);
      if (d < 10) return stip_pkg::CH_ZERO + 8'(d);
      return (stip_pkg::CH_LOWER_A + 8'(d - 10)) & ~(upper ? stip_pkg::CASE_BIT : 8'h00);
   endfunction

   function automatic logic [7:0] x_char();
      return $urandom_range(0, 1) ? stip_pkg::CH_LOWER_X
                                  : (stip_pkg::CH_LOWER_X & ~stip_pkg::CASE_BIT);
   endfunction

   // Build one string: optional white space and sign, a prefix where the base
   // allows one, then a value (often right at a clamp) in the base, and a
   // terminator with trailing junk. Some strings are cut short so that the next
   // start abandons them.
   function automatic char_q_type make_string(logic [stip_pkg::BASE_BITS-1:0] b);
      char_q_type  s;
      logic [7:0]  digs[$];
      logic [63:0] v;
      logic [63:0] lim;
      int          fb;
      int          sgn;
      int          ws;
      sgn = $urandom_range(0, 3);
      repeat ($urandom_range(0, 3)) begin
         ws = $urandom_range(0, 5);
         s.push_back((ws == 5) ? stip_pkg::CH_SPACE : stip_pkg::CH_TAB + 8'(ws));
      end
      if (sgn == 1) s.push_back(stip_pkg::CH_PLUS);
      if (sgn == 2) s.push_back(stip_pkg::CH_MINUS);
      lim = (sgn == 2) ? 64'h8000_0000 : (sgn == 1) ? 64'h7FFF_FFFF : 64'hFFFF_FFFF;
      case ($urandom_range(0, 5))
         0:       v = $urandom_range(0, 99);
         1:       v = $urandom;
         2, 3:    v = lim + 64'($urandom_range(0, 6)) - 64'd3;
         4:       v = {$urandom, $urandom};
         default: v = '0;
      endcase
      fb = (b > 6'd36) ? 36 : int'(b);
      if (b == stip_pkg::BASE_AUTO) begin
         case ($urandom_range(0, 2))
            0: fb = 10;
            1: begin
               fb = 8;
               s.push_back(stip_pkg::CH_ZERO);
            end
            default: begin
               fb = 16;
               s.push_back(stip_pkg::CH_ZERO);
               s.push_back(x_char());
            end
         endcase
      end else if (b == stip_pkg::BASE_HEX && $urandom_range(0, 1) == 1) begin
         s.push_back(stip_pkg::CH_ZERO);
         s.push_back(x_char());
      end
      if (fb < 2) begin
         // radix one (or zero, never latched as such): only '0' is a digit
         repeat ($urandom_range(0, 4)) s.push_back(stip_pkg::CH_ZERO);
      end else if ($urandom_range(0, 9) != 0) begin
         do begin
            digs.push_front(digit_char(int'(v % 64'(fb)), $urandom_range(0, 1)));
            v = v / 64'(fb);
         end while (v != 0);
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2)) digs.push_front(stip_pkg::CH_ZERO);
         foreach (digs[i]) s.push_back(digs[i]);
      end
      if ($urandom_range(0, 9) == 0) return s;
      case ($urandom_range(0, 3))
         0: s.push_back(8'($urandom));
         1: s.push_back(stip_pkg::CH_SPACE);
         2: begin
            case ($urandom_range(0, 4))
               0:       s.push_back(".");
               1:       s.push_back(",");
               2:       s.push_back(";");
               3:       s.push_back(8'h00);
               default: s.push_back(8'hFF);
            endcase
         end
         default: s.push_back(stip_pkg::CH_MINUS);
      endcase
      repeat ($urandom_range(0, 2)) s.push_back(8'($urandom));
      return s;
   endfunction

   initial begin : stimulus
      char_q_type                     text;
      logic [stip_pkg::BASE_BITS-1:0] plan[$];
      logic [stip_pkg::BASE_BITS-1:0] b;
      int                             phase_no;
      int                             phase_start;

      plan = '{stip_pkg::BASE_DEC, stip_pkg::BASE_HEX, stip_pkg::BASE_OCT,
               stip_pkg::BASE_AUTO, 6'd2, 6'd36, 6'd1, 6'd63, 6'd37, 6'd7};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, base register still at its reset value (automatic).
      // Bytes before any start are dropped.
      push_char(8'hFF, 1'b0);
      push_char(8'h00, 1'b0);
      // Tab, plus sign, hex prefix, mixed-case digits landing exactly on the
      // signed clamp.
      text = '{stip_pkg::CH_TAB, stip_pkg::CH_PLUS, stip_pkg::CH_ZERO, stip_pkg::CH_LOWER_X,
               "7", "f", "F", "F", "f", "f", "F", "F", "!"};
      send_string(text);
      // Hex prefix with no digit after it: empty number.
      text = '{stip_pkg::CH_ZERO, stip_pkg::CH_LOWER_X, ";"};
      send_string(text);
      // Leading zero selects octal; the byte after the result is dropped.
      text = '{stip_pkg::CH_ZERO, "1", "7", stip_pkg::CH_SPACE};
      send_string(text);
      push_char("9", 1'b0);
      // Unfinished negative number, abandoned by the next start.
      text = '{stip_pkg::CH_MINUS, "8"};
      send_string(text);

      // Random part: one phase per base setting, written only while idle.
      phase_no = 0;
      while (phase_no < plan.size() || sb.live_chars < LIVE_TARGET) begin
         quiesce();
         b = (phase_no < plan.size()) ? plan[phase_no]
                                      : stip_pkg::BASE_BITS'($urandom_range(0, 63));
         write_base(b);
         // Stall the receiver for a long stretch while characters keep coming.
         if (phase_no == 3) hold_off_req = 1'b1;
         phase_start = sb.live_chars;
         while (sb.live_chars - phase_start < PHASE_CHARS) begin
            text = make_string(b);
            if (text.size() == 0) text.push_back(8'($urandom));
            send_string(text);
            // Stray bytes without a start: dropped, or extend an unfinished string.
            if ($urandom_range(0, 15) == 0)
               repeat ($urandom_range(1, 3)) push_char(8'($urandom), 1'b0);
         end
         phase_no++;
      end

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d strings, %0d parsed characters, %0d base settings",
               sb.strings, sb.live_chars, base_settings);
      $display("checked %0d numbers, %0d of them saturated, %0d errors",
               sb.checked, sb.overflows, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("string_to_integer_parser_unit: match");
      end else begin
         $display("string_to_integer_parser_unit: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/stip_pkg.sv
hdl/stip_ctrl.sv
hdl/stip_dp.sv
hdl/string_to_integer_parser_unit.sv
bench/string_to_integer_parser_unit_tb.sv
